// ----- design/lamc_pkg.sv -----
// Package for the LED animation mode controller.
// Holds mode and phase codes, pattern frame periods and the front-to-back item type.
package lamc_pkg;

  typedef enum logic [2:0] {
    MODE_OFF      = 3'd0,
    MODE_CHASE    = 3'd1,
    MODE_FILL     = 3'd2,
    MODE_BLINK    = 3'd3,
    MODE_PINGPONG = 3'd4,
    MODE_SPARKLE  = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_OUT  = 2'd1,
    PHASE_IN   = 2'd2
  } phase_e;

  localparam logic [2:0] REG_BRIGHTNESS   = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd2;
  localparam logic [2:0] REG_FRAME_STEP   = 3'd3;
  localparam logic [2:0] REG_MODE_STEP    = 3'd4;
  localparam logic [2:0] REG_FRAME_IVL    = 3'd5;
  localparam logic [2:0] REG_MODE_IVL     = 3'd6;
  localparam logic [2:0] REG_ACTIVE_HIGH  = 3'd7;

  localparam logic [8:0] CHASE_PERIOD    = 9'd120;
  localparam logic [8:0] FILL_PERIOD     = 9'd180;
  localparam logic [8:0] BLINK_PERIOD    = 9'd300;
  localparam logic [8:0] PINGPONG_PERIOD = 9'd120;
  localparam logic [8:0] SPARKLE_PERIOD  = 9'd90;

  localparam int unsigned OUT_LEDS = 5;

  // Classified tick handed from the front to the back.
  typedef struct packed {
    logic       press;      // debounced press accepted this tick
    logic       rel_step;   // debounced release that may step the mode
    logic       long_chk;   // press held long enough, done and phase checks left out
    logic [2:0] pick_first;
    logic [2:0] pick_second;
    logic       stable;
  } tick_t;

  typedef struct packed {
    logic [7:0] led0_level;
    logic [7:0] led1_level;
    logic [7:0] led2_level;
    logic [7:0] led3_level;
    logic [7:0] led4_level;
    logic [2:0] mode;
    logic [1:0] phase;
    logic       button_stable;
  } res_t;

  typedef struct packed {
    logic       button_raw;
    logic [2:0] pick_first;
    logic [2:0] pick_second;
  } item_t;

endpackage

// ----- design/lamc_stream_if.sv -----
// Valid/ready stream interface with a generic payload type.
// It does not import lamc_pkg; the payload type is set by the parameter T.
interface lamc_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/led_animation_mode_controller.sv -----
// Top level of the LED animation mode controller.
// Depends on lamc_pkg, lamc_stream_if, lamc_front and lamc_back.
//
// One input beat is one millisecond tick; each tick yields exactly one result beat
// carrying the five LED levels, the mode, the transition phase and the debounced
// button. The front debounces the button and writes the classified tick into a
// two-entry queue at the accepting edge; the back takes it from the queue and
// registers the result, so a tick passes the queue entry and then the result register
// before its result can be taken. The block sustains one tick per cycle while
// results are taken; with the result held, it takes two more ticks into the queue
// and then stalls its input.
module led_animation_mode_controller
  import lamc_pkg::*;
#(
  parameter int unsigned LED_COUNT = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lamc_stream_if.sink   in_if,
  lamc_stream_if.source out_if,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [7:0]  bright_q, deb_q, fstep_q, mstep_q, fivl_q, mivl_q;
  logic [15:0] long_q;
  logic        ah_q;
  logic        q_valid, q_ready;
  tick_t       q_data;
  res_t        res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q <= 8'd25; deb_q <= 8'd35; long_q <= 16'd3000; fstep_q <= 8'd24;
      mstep_q <= 8'd12; fivl_q <= 8'd12; mivl_q <= 8'd10; ah_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BRIGHTNESS:  bright_q <= cfg_wdata_i[7:0];
        REG_DEBOUNCE:    deb_q    <= cfg_wdata_i[7:0];
        REG_LONG_PRESS:  long_q   <= cfg_wdata_i;
        REG_FRAME_STEP:  fstep_q  <= cfg_wdata_i[7:0];
        REG_MODE_STEP:   mstep_q  <= cfg_wdata_i[7:0];
        REG_FRAME_IVL:   fivl_q   <= cfg_wdata_i[7:0];
        REG_MODE_IVL:    mivl_q   <= cfg_wdata_i[7:0];
        default:         ah_q     <= cfg_wdata_i[0];
      endcase
    end
  end

  lamc_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready), .in_data_i(in_if.data),
    .debounce_ticks_i(deb_q), .long_press_ticks_i(long_q), .active_high_i(ah_q),
    .q_valid_o(q_valid), .q_ready_i(q_ready), .q_data_o(q_data)
  );

  lamc_back #(.LedCount(LED_COUNT)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_ready_o(q_ready), .q_data_i(q_data),
    .brightness_i(bright_q), .frame_step_i(fstep_q), .mode_step_i(mstep_q),
    .frame_ivl_i(fivl_q), .mode_ivl_i(mivl_q),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready), .out_data_o(res)
  );

  assign out_if.data = res;

  a_phase_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.phase == PHASE_IDLE || res.phase == PHASE_OUT || res.phase == PHASE_IN)
    else $error("phase code out of range");
  a_mode_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.mode <= MODE_SPARKLE) else $error("mode out of range");
  a_idle_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && res.phase == PHASE_IDLE && res.mode == MODE_OFF) |->
    (res.led0_level == 8'd0 && res.led1_level == 8'd0 && res.led2_level == 8'd0 &&
     res.led3_level == 8'd0 && res.led4_level == 8'd0)) else $error("off mode lit");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(res)))
    else $error("result beat changed while stalled");

endmodule

// ----- design/lamc_front.sv -----
// Front part: button debounce and press timing, one tick per accepted beat.
// Depends on lamc_pkg. The fade-phase gating of presses is left to the back part.
module lamc_front
  import lamc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_data_i,
  input  logic [7:0]  debounce_ticks_i,
  input  logic [15:0] long_press_ticks_i,
  input  logic        active_high_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output tick_t       q_data_o
);

  logic        raw_last_q, raw_last_d;
  logic        deb_q, deb_d;
  logic [7:0]  raw_hold_q, raw_hold_d;
  logic [15:0] press_hold_q, press_hold_d;
  logic        pressed, acc, pop;
  tick_t       tk;
  tick_t       fifo_q [2];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;

  // Two-entry queue toward the back.
  assign in_ready_o = (cnt_q != 2'd2);
  assign acc        = in_valid_i & in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o & q_ready_i;
  assign q_data_o   = fifo_q[rd_q];

  always_comb begin
    logic [7:0]  rh;
    logic [15:0] ph;
    rh = (raw_hold_q == 8'hFF) ? raw_hold_q : raw_hold_q + 8'd1;
    ph = (press_hold_q == 16'hFFFF) ? press_hold_q : press_hold_q + 16'd1;
    pressed = active_high_i ? in_data_i.button_raw : ~in_data_i.button_raw;
    raw_last_d = raw_last_q;
    deb_d = deb_q;
    tk = '0;
    tk.pick_first = in_data_i.pick_first;
    tk.pick_second = in_data_i.pick_second;
    if (pressed != raw_last_q) begin
      raw_last_d = pressed;
      rh = 8'd0;
    end
    if (rh < debounce_ticks_i || deb_q == pressed) begin
      tk.long_chk = deb_q & (ph >= long_press_ticks_i);
    end else begin
      deb_d = pressed;
      if (pressed) begin
        ph = 16'd0;
        tk.press = 1'b1;
      end else begin
        tk.rel_step = 1'b1;
      end
    end
    tk.stable = deb_d;
    raw_hold_d = rh;
    press_hold_d = ph;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_last_q <= 1'b0;
      deb_q <= 1'b0;
      raw_hold_q <= '0;
      press_hold_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
      for (int i = 0; i < 2; i++) fifo_q[i] <= '0;
    end else begin
      if (acc) begin
        raw_last_q <= raw_last_d;
        deb_q <= deb_d;
        raw_hold_q <= raw_hold_d;
        press_hold_q <= press_hold_d;
        fifo_q[wr_q] <= tk;
        wr_q <= ~wr_q;
      end
      if (pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, acc} - {1'b0, pop};
    end
  end

endmodule

// ----- design/lamc_back.sv -----
// Back part: transition fades, pattern frames and level smoothing.
// Depends on lamc_pkg. Takes one classified tick per beat, emits one result.
module lamc_back
  import lamc_pkg::*;
#(
  parameter int unsigned LedCount = 5
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  tick_t      q_data_i,
  input  logic [7:0] brightness_i,
  input  logic [7:0] frame_step_i,
  input  logic [7:0] mode_step_i,
  input  logic [7:0] frame_ivl_i,
  input  logic [7:0] mode_ivl_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output res_t       out_data_o
);

  localparam int unsigned IdxW = $clog2(LedCount);

  logic [2:0] mode_q, mode_d, pend_q, pend_d;
  logic [1:0] phase_q, phase_d;
  logic [7:0] fade_q, fade_d, fcnt_q, fcnt_d;
  logic [7:0] pp_q, pp_d;
  logic [1:0] m3_q, m3_d;
  logic       done_q, done_d;
  logic [8:0] fwait_q, fwait_d;
  logic [7:0] lwait_q, lwait_d, mwait_q, mwait_d;
  logic [7:0] smooth_q [LedCount];
  logic [7:0] smooth_d [LedCount];
  logic [7:0] tgt_q [LedCount];
  logic [7:0] tgt_d [LedCount];
  logic [7:0] pin_q [LedCount];
  logic [7:0] pin_d [LedCount];
  logic       stable_q;
  logic       ov_q;
  logic       acc;

  assign q_ready_o   = ~ov_q | out_ready_i;
  assign acc         = q_valid_i & q_ready_o;
  assign out_valid_o = ov_q;

  function automatic logic [7:0] step_up(logic [7:0] s, logic [7:0] st, logic [7:0] t);
    logic [8:0] v;
    v = {1'b0, s} + {1'b0, st};
    if (v > 9'd255) v = 9'd255;
    return (v[7:0] < t) ? v[7:0] : t;
  endfunction

  always_comb begin
    logic       idle, lit, wrap;
    logic [8:0] per;
    logic [2:0] m;
    logic [7:0] pos, path;
    mode_d = mode_q; pend_d = pend_q; phase_d = phase_q; fade_d = fade_q;
    fcnt_d = fcnt_q; pp_d = pp_q; m3_d = m3_q; done_d = done_q;
    fwait_d = (fwait_q == 9'h1FF) ? fwait_q : fwait_q + 9'd1;
    lwait_d = (lwait_q == 8'hFF) ? lwait_q : lwait_q + 8'd1;
    mwait_d = (mwait_q == 8'hFF) ? mwait_q : mwait_q + 8'd1;
    smooth_d = smooth_q; tgt_d = tgt_q; pin_d = pin_q;
    per = CHASE_PERIOD; lit = 1'b0; wrap = 1'b0; m = MODE_OFF; pos = '0;
    path = 8'((LedCount * 2) - 2);
    idle = (phase_q != PHASE_OUT) && (phase_q != PHASE_IN);
    // press handling
    if (q_data_i.press) done_d = 1'b0;
    if (idle && q_data_i.long_chk && !done_q) begin
      done_d = 1'b1;
      pend_d = MODE_OFF; phase_d = PHASE_OUT; fade_d = brightness_i; mwait_d = 8'hFF;
    end else if (idle && q_data_i.rel_step && !done_q) begin
      m = (mode_q >= MODE_SPARKLE) ? MODE_CHASE : mode_q + 3'd1;
      pend_d = m; phase_d = PHASE_OUT; fade_d = brightness_i; mwait_d = 8'hFF;
    end
    // transition
    if ((phase_d == PHASE_OUT || phase_d == PHASE_IN) && mwait_d >= mode_ivl_i) begin
      mwait_d = '0;
      if (phase_d == PHASE_OUT) begin
        if (fade_d > mode_step_i) begin
          fade_d = fade_d - mode_step_i;
          for (int i = 0; i < LedCount; i++) pin_d[i] = fade_d;
        end else begin
          mode_d = pend_d; fcnt_d = '0; pp_d = '0; m3_d = '0;
          fwait_d = 9'h1FF; lwait_d = 8'hFF;
          for (int i = 0; i < LedCount; i++) begin
            tgt_d[i] = '0; smooth_d[i] = '0; pin_d[i] = '0;
          end
          phase_d = PHASE_IN; fade_d = '0;
        end
      end else if (fade_d < brightness_i) begin
        fade_d = step_up(fade_d, mode_step_i, brightness_i);
        for (int i = 0; i < LedCount; i++) pin_d[i] = fade_d;
      end else begin
        for (int i = 0; i < LedCount; i++) begin
          tgt_d[i] = '0; smooth_d[i] = '0; pin_d[i] = '0;
        end
        phase_d = PHASE_IDLE;
      end
    end
    if (phase_d != PHASE_OUT && phase_d != PHASE_IN) begin
      unique case (mode_d)
        MODE_CHASE:    per = CHASE_PERIOD;
        MODE_FILL:     per = FILL_PERIOD;
        MODE_BLINK:    per = BLINK_PERIOD;
        MODE_PINGPONG: per = PINGPONG_PERIOD;
        MODE_SPARKLE:  per = SPARKLE_PERIOD;
        default:       per = CHASE_PERIOD;
      endcase
      if (mode_d == MODE_OFF || mode_d > MODE_SPARKLE) begin
        mode_d = MODE_OFF;
        for (int i = 0; i < LedCount; i++) tgt_d[i] = '0;
      end else if (fwait_d >= per) begin
        fwait_d = '0;
        pos = pp_d;  // frame_count mod path
        for (int i = 0; i < LedCount; i++) begin
          case (mode_d)
            MODE_CHASE: lit = (8'(i) == fcnt_d);
            MODE_FILL:  lit = (8'(i) < fcnt_d);
            MODE_BLINK: lit = ~fcnt_d[0];
            MODE_PINGPONG:
              lit = (pos < 8'(LedCount)) ? (8'(i) == pos) : (8'(i) == path - pos);
            default:
              lit = (8'(i) == {5'd0, q_data_i.pick_first}) ||
                    ((m3_d == 2'd0) && 8'(i) == {5'd0, q_data_i.pick_second});
          endcase
          tgt_d[i] = lit ? brightness_i : 8'd0;
        end
        // track frame_count mod path and mod 3 alongside the 8-bit count
        wrap = (fcnt_d == 8'hFF);
        pp_d = wrap ? 8'd0 : ((pp_d + 8'd1 >= path) ? 8'd0 : pp_d + 8'd1);
        m3_d = (wrap || m3_d == 2'd2) ? 2'd0 : m3_d + 2'd1;
        case (mode_d)
          MODE_CHASE: fcnt_d = (fcnt_d + 8'd1 >= 8'(LedCount)) ? 8'd0 : fcnt_d + 8'd1;
          MODE_FILL:  fcnt_d = (fcnt_d + 8'd1 >= 8'(LedCount + 1)) ? 8'd0 : fcnt_d + 8'd1;
          default:    fcnt_d = fcnt_d + 8'd1;
        endcase
      end
      if (lwait_d >= frame_ivl_i) begin
        lwait_d = '0;
        for (int i = 0; i < LedCount; i++) begin
          if (smooth_d[i] < tgt_d[i]) smooth_d[i] = step_up(smooth_d[i], frame_step_i, tgt_d[i]);
          else if (smooth_d[i] > tgt_d[i]) begin
            if (smooth_d[i] > frame_step_i && smooth_d[i] - frame_step_i > tgt_d[i])
              smooth_d[i] = smooth_d[i] - frame_step_i;
            else smooth_d[i] = tgt_d[i];
          end
          pin_d[i] = smooth_d[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OFF; pend_q <= MODE_OFF; phase_q <= PHASE_IDLE;
      fade_q <= '0; fcnt_q <= '0; fwait_q <= 9'h1FF; lwait_q <= 8'hFF; mwait_q <= 8'hFF;
      pp_q <= '0; m3_q <= '0; done_q <= 1'b0;
      stable_q <= 1'b0; ov_q <= 1'b0;
      for (int i = 0; i < LedCount; i++) begin
        smooth_q[i] <= '0; tgt_q[i] <= '0; pin_q[i] <= '0;
      end
    end else begin
      if (acc) begin
        mode_q <= mode_d; pend_q <= pend_d; phase_q <= phase_d; fade_q <= fade_d;
        fcnt_q <= fcnt_d; fwait_q <= fwait_d; lwait_q <= lwait_d; mwait_q <= mwait_d;
        pp_q <= pp_d; m3_q <= m3_d; done_q <= done_d;
        stable_q <= q_data_i.stable;
        smooth_q <= smooth_d; tgt_q <= tgt_d; pin_q <= pin_d;
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_comb begin
    logic [7:0] lv [OUT_LEDS];
    for (int k = 0; k < OUT_LEDS; k++) lv[k] = (k < LedCount) ? pin_q[IdxW'(k)] : 8'd0;
    out_data_o.led0_level = lv[0];
    out_data_o.led1_level = lv[1];
    out_data_o.led2_level = lv[2];
    out_data_o.led3_level = lv[3];
    out_data_o.led4_level = lv[4];
    out_data_o.mode = mode_q;
    out_data_o.phase = phase_q;
    out_data_o.button_stable = stable_q;
  end

endmodule
